// ===== rtl/bcsa_pkg.sv =====
`default_nettype none
package bcsa_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 4096;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_SOURCE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_DEST_ADDRESS   = 2'd1;
    localparam logic [1:0] CFG_BROADCAST_MODE = 2'd2;
    localparam logic [1:0] CFG_NEW_CHANNEL    = 2'd3;

    localparam logic [7:0] FC_TYPE_MASK    = 8'h0C;
    localparam logic [7:0] FC_SUBTYPE_MASK = 8'hF0;
    localparam logic [7:0] FC_BEACON       = 8'h80;
    localparam logic [7:0] MAX_PLAIN_ID    = 8'd37;
    localparam logic [7:0] CSA_ID          = 8'h25;
    localparam logic [7:0] CSA_LEN         = 8'h03;
    localparam logic [7:0] CSA_MODE        = 8'h01;
    localparam logic [7:0] CSA_COUNT       = 8'h03;
    localparam logic [7:0] ALL_ONES        = 8'hFF;
    localparam int MAC_HDR_BYTES = 24;
    localparam int FIXED_BYTES   = 12;
    localparam int CSA_BYTES     = 5;

    typedef struct packed {
        logic [47:0] source_address;
        logic [47:0] dest_address;
        logic        broadcast_mode;
    } cfg_t;

    // one accepted byte as the back end needs it
    typedef struct packed {
        logic [7:0] ob;
        logic       byte_last;
        logic       beacon;
        logic [7:0] chan;
        logic       found;
        logic       ins_before;
        logic       append;
    } cmd_t;

    function automatic logic [7:0] octet_of(input logic [47:0] addr, input logic [2:0] idx);
        logic [7:0] o;
        case (idx)
            3'd0: o = addr[47:40];
            3'd1: o = addr[39:32];
            3'd2: o = addr[31:24];
            3'd3: o = addr[23:16];
            3'd4: o = addr[15:8];
            3'd5: o = addr[7:0];
            default: o = 8'h00;
        endcase
        return o;
    endfunction

    function automatic logic [7:0] csa_byte(input logic [2:0] idx, input logic [7:0] ch);
        logic [7:0] o;
        case (idx)
            3'd0: o = CSA_ID;
            3'd1: o = CSA_LEN;
            3'd2: o = CSA_MODE;
            3'd3: o = ch;
            3'd4: o = CSA_COUNT;
            default: o = 8'h00;
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bcsa_front.sv =====
`default_nettype none
module bcsa_front #(
    parameter int MAX_FRAME_BYTES = bcsa_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    input  wire bcsa_pkg::cfg_t cfg,
    output bcsa_pkg::cmd_t     cmd
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [1:0] PH_ID   = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_CHAN = 2'd3;
    localparam logic [16:0] ELEM_OFS = 17'(bcsa_pkg::MAC_HDR_BYTES + bcsa_pkg::FIXED_BYTES);

    logic [PW-1:0] pos_reg, pos_next;
    logic [15:0]   rlen_reg, rlen_next;
    logic          beacon_reg, beacon_next;
    logic [8:0]    rem_reg, rem_next;
    logic [1:0]    phase_reg, phase_next;
    logic [1:0]    count_reg, count_next;
    logic          ins_reg, ins_next;
    logic [7:0]    chan_reg, chan_next;

    always_comb
    begin
        logic [16:0] p;
        logic [16:0] r;
        logic [16:0] dofs;
        logic [16:0] sofs;
        logic        ins_b;
        logic        app;
        logic        do_id;
        logic [7:0]  ob;

        pos_next    = pos_reg;
        rlen_next   = rlen_reg;
        beacon_next = beacon_reg;
        rem_next    = rem_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        ins_next    = ins_reg;
        chan_next   = chan_reg;
        ins_b       = 1'b0;
        do_id       = 1'b0;
        ob          = in_byte;
        p           = 17'(pos_reg);
        r           = '0;
        dofs        = '0;
        sofs        = '0;

        if (pos_reg < PW'(MAX_FRAME_BYTES))
        begin
            if (p == 17'd2)
                rlen_next[7:0] = in_byte;
            else if (p == 17'd3)
                rlen_next[15:8] = in_byte;
            r = {1'b0, rlen_next};
            dofs = p - r - 17'd4;
            sofs = p - r - 17'd10;
            if (p >= 17'd4)
            begin
                if (p == r)
                    beacon_next = ((in_byte & bcsa_pkg::FC_TYPE_MASK) == 8'h00)
                               && ((in_byte & bcsa_pkg::FC_SUBTYPE_MASK) == bcsa_pkg::FC_BEACON);
                if (beacon_next && p >= r + 17'd4 && p < r + 17'd10)
                    ob = cfg.broadcast_mode ? bcsa_pkg::ALL_ONES
                                            : bcsa_pkg::octet_of(cfg.dest_address, dofs[2:0]);
                else if (beacon_next && p >= r + 17'd10 && p < r + 17'd16)
                    ob = bcsa_pkg::octet_of(cfg.source_address, sofs[2:0]);
                // tagged element walk
                if (p >= r + ELEM_OFS)
                begin
                    case (phase_reg)
                        PH_CHAN:
                        begin
                            chan_next  = in_byte;
                            count_next = 2'd3;
                            if (rem_reg == 9'd0)
                                do_id = 1'b1;
                            else
                            begin
                                rem_next   = rem_reg - 9'd1;
                                phase_next = (rem_next != 9'd0) ? PH_BODY : PH_ID;
                            end
                        end
                        PH_ID:
                            do_id = 1'b1;
                        PH_LEN:
                        begin
                            rem_next = {1'b0, in_byte};
                            if (count_reg == 2'd2)
                                phase_next = PH_CHAN;
                            else
                            begin
                                if (count_reg < 2'd2)
                                    count_next = count_reg + 2'd1;
                                phase_next = (in_byte != 8'h00) ? PH_BODY : PH_ID;
                            end
                        end
                        default:
                        begin
                            rem_next = rem_reg - 9'd1;
                            if (rem_next == 9'd0)
                                phase_next = PH_ID;
                        end
                    endcase
                    if (do_id)
                    begin
                        if (beacon_next && !ins_reg && in_byte > bcsa_pkg::MAX_PLAIN_ID)
                        begin
                            ins_b    = 1'b1;
                            ins_next = 1'b1;
                        end
                        phase_next = PH_LEN;
                    end
                end
            end
            pos_next = pos_reg + PW'(1);
        end

        app = in_last && beacon_next && !ins_next;

        cmd.ob         = ob;
        cmd.byte_last  = in_last && !app;
        cmd.beacon     = beacon_next;
        cmd.chan       = chan_next;
        cmd.found      = (count_next == 2'd3);
        cmd.ins_before = ins_b;
        cmd.append     = app;

        if (in_last)
        begin
            pos_next    = '0;
            rlen_next   = '0;
            beacon_next = 1'b0;
            rem_next    = '0;
            phase_next  = PH_ID;
            count_next  = '0;
            ins_next    = 1'b0;
            chan_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            rlen_reg   <= '0;
            beacon_reg <= 1'b0;
            rem_reg    <= '0;
            phase_reg  <= PH_ID;
            count_reg  <= '0;
            ins_reg    <= 1'b0;
            chan_reg   <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            rlen_reg   <= rlen_next;
            beacon_reg <= beacon_next;
            rem_reg    <= rem_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            ins_reg    <= ins_next;
            chan_reg   <= chan_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bcsa_queue.sv =====
`default_nettype none
module bcsa_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire bcsa_pkg::cmd_t wr_data,
    output logic                q_full,
    input  wire logic           rd,
    output bcsa_pkg::cmd_t      rd_data,
    output logic                q_empty
);

    localparam int AW = $clog2(bcsa_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(bcsa_pkg::QUEUE_DEPTH + 1);

    bcsa_pkg::cmd_t mem [bcsa_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr, do_rd;

    assign q_full  = (cnt_reg == CW'(bcsa_pkg::QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == AW'(bcsa_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (do_rd)
                rp_reg <= (rp_reg == AW'(bcsa_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bcsa_back.sv =====
`default_nettype none
module bcsa_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bcsa_pkg::cmd_t head,
    input  wire logic           head_empty,
    output logic                head_pop,
    input  wire logic [7:0]     new_channel,
    input  wire logic           pop,
    output logic                empty,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic                is_beacon,
    output logic [7:0]          old_channel,
    output logic                channel_found
);

    logic [2:0] beat_reg, beat_next;
    logic       multi;
    logic       final_beat;
    logic       take;

    assign multi      = head.ins_before || head.append;
    assign final_beat = multi ? (beat_reg == 3'(bcsa_pkg::CSA_BYTES)) : 1'b1;
    assign empty      = head_empty;
    assign take       = pop && !head_empty;
    assign head_pop   = take && final_beat;
    assign beat_next  = final_beat ? 3'd0 : beat_reg + 3'd1;

    always_comb
    begin
        logic csa_tail;
        is_beacon = head.beacon;
        csa_tail  = 1'b0;
        if (head.ins_before && beat_reg < 3'(bcsa_pkg::CSA_BYTES))
        begin
            out_byte      = bcsa_pkg::csa_byte(beat_reg, new_channel);
            out_last      = 1'b0;
            old_channel   = 8'h00;
            channel_found = 1'b0;
        end
        else if (head.append && beat_reg != 3'd0)
        begin
            csa_tail      = (beat_reg == 3'(bcsa_pkg::CSA_BYTES));
            out_byte      = bcsa_pkg::csa_byte(beat_reg - 3'd1, new_channel);
            out_last      = csa_tail;
            old_channel   = csa_tail ? head.chan : 8'h00;
            channel_found = csa_tail && head.found;
        end
        else
        begin
            out_byte      = head.ob;
            out_last      = head.byte_last;
            old_channel   = head.byte_last ? head.chan : 8'h00;
            channel_found = head.byte_last && head.found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_reg <= '0;
        else if (take)
            beat_reg <= beat_next;
    end

    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        beat_reg <= 3'(bcsa_pkg::CSA_BYTES))
        else $error("beat counter out of range");

    a_beat_multi: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_reg != 3'd0) |-> (!head_empty && multi))
        else $error("beat counter running on a single-beat entry");

    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        (!head_empty && out_last) |-> final_beat)
        else $error("frame end marked before the entry's final beat");

    a_hold_head: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !final_beat) |=> (!head_empty && beat_reg == $past(beat_reg) + 3'd1))
        else $error("entry left the queue before its beats were done");

endmodule
`default_nettype wire

// ===== rtl/beacon_csa_element_inserter.sv =====
`default_nettype none
// channel   | direction | handshake            | payload
// input     | in        | push / full          | in_byte, in_last
// result    | out       | empty / pop          | out_byte, out_last, is_beacon,
//           |           |                      | old_channel, channel_found
// config    | in        | cfg_write            | cfg_index, cfg_data
//
// one input byte per cycle while full is low; a byte becomes one result beat, or
// six when the switch element goes in before it or after the frame's final byte
// the back end drains one beat per cycle from the four-entry command queue while
// pop is high and it is not empty; an inserted element adds five beats per frame
// full rises only when the queue holds four entries; empty follows the queue
// reset clears the parser, the queue pointers and the registers to defaults
module beacon_csa_element_inserter #(
    parameter int MAX_FRAME_BYTES = bcsa_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             is_beacon,
    output logic [7:0]       old_channel,
    output logic             channel_found,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    bcsa_pkg::cfg_t cfg_reg;
    logic [7:0]     new_channel_reg;
    bcsa_pkg::cmd_t cmd;
    bcsa_pkg::cmd_t head;
    logic           head_empty;
    logic           head_pop;
    logic           accept;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_address <= '0;
            cfg_reg.dest_address   <= '1;
            cfg_reg.broadcast_mode <= 1'b1;
            new_channel_reg        <= 8'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bcsa_pkg::CFG_SOURCE_ADDRESS: cfg_reg.source_address <= cfg_data;
                bcsa_pkg::CFG_DEST_ADDRESS:   cfg_reg.dest_address   <= cfg_data;
                bcsa_pkg::CFG_BROADCAST_MODE: cfg_reg.broadcast_mode <= cfg_data[0];
                bcsa_pkg::CFG_NEW_CHANNEL:    new_channel_reg        <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    bcsa_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .cfg     (cfg_reg),
        .cmd     (cmd)
    );

    bcsa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (accept),
        .wr_data (cmd),
        .q_full  (full),
        .rd      (head_pop),
        .rd_data (head),
        .q_empty (head_empty)
    );

    bcsa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_empty    (head_empty),
        .head_pop      (head_pop),
        .new_channel   (new_channel_reg),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .is_beacon     (is_beacon),
        .old_channel   (old_channel),
        .channel_found (channel_found)
    );

endmodule
`default_nettype wire

// ===== test/tb_beacon_csa_element_inserter.sv =====
`timescale 1ns / 1ps

module tb_beacon_csa_element_inserter;

    // small frame limit so that saturation is reached with short frames
    localparam int MAX_FRAME       = 96;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 20;
    localparam int CHOKE_CYCLES    = 300;
    localparam int LIMIT_CYCLES    = 5000000;
    localparam int ITEMS_PER_PHASE = 45;

    typedef enum logic [1:0] {EL_ID, EL_LEN, EL_BODY, EL_CHAN} el_phase_t;

    typedef enum int {
        FR_INSERT, FR_APPEND, FR_ZERO_THIRD, FR_OTHER_TYPE, FR_CUT, FR_NOISE, FR_LONG
    } frame_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       beacon;
        logic [7:0] chan;
        logic       found;
    } beat_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    logic [7:0]  in_byte   = 8'h00;
    logic        in_last   = 1'b0;
    logic        empty;
    logic        pop       = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        is_beacon;
    logic [7:0]  old_channel;
    logic        channel_found;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = bcsa_pkg::CFG_SOURCE_ADDRESS;
    logic [47:0] cfg_data  = '0;

    beacon_csa_element_inserter #(
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .in_last       (in_last),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .is_beacon     (is_beacon),
        .old_channel   (old_channel),
        .channel_found (channel_found),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    in_item_t byte_feed[$];
    beat_t    rewritten_q[$];
    int       queued_items = 0;
    int       taken_items  = 0;
    int       bad_beats    = 0;
    int       frame_no     = 0;
    int       cycle_count  = 0;
    logic     in_taken     = 1'b0;
    int       tx_gap       = 0;
    int       tx_calm      = 0;
    int       rx_hold      = 0;
    int       rx_calm      = 0;
    logic     choke_req    = 1'b0;
    logic     choke_done   = 1'b0;

    // register mirror
    logic [47:0] m_src;
    logic [47:0] m_dst;
    logic        m_bcast;
    logic [7:0]  m_new_chan;

    // per-frame parser mirror
    int unsigned pos;
    logic [15:0] rt_len;
    bit          bcn;
    logic [8:0]  el_left;
    el_phase_t   el_phase;
    int          el_count;
    bit          inserted;
    logic [7:0]  chan_seen;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void clear_frame_state();
        pos       = 0;
        rt_len    = '0;
        bcn       = 1'b0;
        el_left   = '0;
        el_phase  = EL_ID;
        el_count  = 0;
        inserted  = 1'b0;
        chan_seen = '0;
    endfunction

    function automatic logic [7:0] addr_octet(input logic [47:0] a, input int unsigned i);
        return a[47 - 8 * i -: 8];
    endfunction

    function automatic void emit(input logic [7:0] d, input bit last);
        beat_t t;
        t.data   = d;
        t.last   = last;
        t.beacon = bcn;
        t.chan   = last ? chan_seen : 8'h00;
        t.found  = last && (el_count == 3);
        rewritten_q.push_back(t);
    endfunction

    function automatic void emit_switch_elem(input bit last_at_end);
        emit(bcsa_pkg::CSA_ID, 1'b0);
        emit(bcsa_pkg::CSA_LEN, 1'b0);
        emit(bcsa_pkg::CSA_MODE, 1'b0);
        emit(m_new_chan, 1'b0);
        emit(bcsa_pkg::CSA_COUNT, last_at_end);
    endfunction

    // tagged element walk; returns 1 when the switch element goes in front of b
    function automatic bit walk_elem(input logic [7:0] b);
        if (el_phase == EL_CHAN)
        begin
            chan_seen = b;
            el_count  = 3;
            if (el_left == 9'd0)
                el_phase = EL_ID;
            else
            begin
                el_left  = el_left - 9'd1;
                el_phase = (el_left != 9'd0) ? EL_BODY : EL_ID;
                return 1'b0;
            end
        end
        if (el_phase == EL_ID)
        begin
            el_phase = EL_LEN;
            if (bcn && !inserted && b > bcsa_pkg::MAX_PLAIN_ID)
            begin
                inserted = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        if (el_phase == EL_LEN)
        begin
            el_left = {1'b0, b};
            if (el_count == 2)
                el_phase = EL_CHAN;
            else
            begin
                if (el_count < 2)
                    el_count++;
                el_phase = (b != 8'd0) ? EL_BODY : EL_ID;
            end
            return 1'b0;
        end
        el_left = el_left - 9'd1;
        if (el_left == 9'd0)
            el_phase = EL_ID;
        return 1'b0;
    endfunction

    function automatic void rewrite_byte(input logic [7:0] b, input bit last);
        int unsigned p;
        logic [7:0]  ob;
        bit          ins;
        bit          app;
        p   = pos;
        ob  = b;
        ins = 1'b0;
        if (p < MAX_FRAME)
        begin
            if (p == 2)
                rt_len[7:0] = b;
            else if (p == 3)
                rt_len[15:8] = b;
            if (p >= 4)
            begin
                if (p == rt_len)
                    bcn = ((b & bcsa_pkg::FC_TYPE_MASK) == 8'h00)
                       && ((b & bcsa_pkg::FC_SUBTYPE_MASK) == bcsa_pkg::FC_BEACON);
                if (bcn && p >= rt_len + 4 && p < rt_len + 10)
                    ob = m_bcast ? bcsa_pkg::ALL_ONES : addr_octet(m_dst, p - rt_len - 4);
                else if (bcn && p >= rt_len + 10 && p < rt_len + 16)
                    ob = addr_octet(m_src, p - rt_len - 10);
                if (p >= rt_len + bcsa_pkg::MAC_HDR_BYTES + bcsa_pkg::FIXED_BYTES)
                    ins = walk_elem(b);
            end
            pos = p + 1;
        end
        if (ins)
            emit_switch_elem(1'b0);
        app = last && bcn && !inserted;
        emit(ob, last && !app);
        if (app)
        begin
            inserted = 1'b1;
            emit_switch_elem(1'b1);
        end
        if (last)
            clear_frame_state();
    endfunction

    function automatic logic [7:0] rand_octet();
        return 8'($urandom);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void add_bytes(input logic [7:0] fb[$]);
        in_item_t it;
        foreach (fb[i])
        begin
            it.data = fb[i];
            it.last = (i == fb.size() - 1);
            byte_feed.push_back(it);
        end
        queued_items += fb.size();
    endfunction

    function automatic void add_frame(input frame_kind_t kind);
        logic [7:0]  fb[$];
        int unsigned rt;
        int          n_el;
        int          ins_at;
        int          ln;
        int          id;
        int          cut;
        logic [7:0]  fc;
        if (kind == FR_NOISE)
        begin
            repeat ($urandom_range(1, 20)) fb.push_back(rand_octet());
            add_bytes(fb);
            return;
        end
        rt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 16);
        fb.push_back(rand_octet());
        fb.push_back(rand_octet());
        fb.push_back(rt[7:0]);
        fb.push_back(rt[15:8]);
        while (fb.size() < rt)
            fb.push_back(rand_octet());
        fc = rand_octet();
        if (kind == FR_OTHER_TYPE)
        begin
            if (fc[7:4] == 4'h8 && fc[3:2] == 2'b00)
                fc[2] = 1'b1;
        end
        else
            fc[7:2] = 6'b100000;
        fb.push_back(fc);
        while (fb.size() < rt + bcsa_pkg::MAC_HDR_BYTES + bcsa_pkg::FIXED_BYTES)
            fb.push_back(rand_octet());

        n_el = (kind == FR_LONG) ? 0 : $urandom_range(3, 6);
        if (kind == FR_INSERT)
            ins_at = $urandom_range(0, n_el - 1);
        else if (kind == FR_APPEND)
            ins_at = n_el;
        else
            ins_at = $urandom_range(0, n_el);
        for (int k = 0; k < n_el; k++)
        begin
            if (k < ins_at)
                id = $urandom_range(0, bcsa_pkg::MAX_PLAIN_ID);
            else if (k == ins_at)
                id = ($urandom_range(0, 3) == 0) ? bcsa_pkg::MAX_PLAIN_ID + 1
                                                 : $urandom_range(bcsa_pkg::MAX_PLAIN_ID + 1, 255);
            else
                id = $urandom_range(0, 255);
            if (kind == FR_ZERO_THIRD && k == 2)
                ln = 0;
            else if ($urandom_range(0, 39) == 0)
                ln = $urandom_range(60, 255);
            else
                ln = $urandom_range(0, 5);
            fb.push_back(8'(id));
            fb.push_back(8'(ln));
            repeat (ln) fb.push_back(rand_octet());
        end

        // runs past the position counter's saturation point
        if (kind == FR_LONG)
            while (fb.size() <= MAX_FRAME + 16)
            begin
                fb.push_back(8'($urandom_range(0, bcsa_pkg::MAX_PLAIN_ID)));
                fb.push_back(8'h10);
                repeat (16) fb.push_back(rand_octet());
            end

        if (kind == FR_CUT)
        begin
            cut = $urandom_range(1, fb.size());
            while (fb.size() > cut)
                void'(fb.pop_back());
        end
        add_bytes(fb);
    endfunction

    function automatic void run_frames(input int n);
        int          stop;
        int          r;
        frame_kind_t kind;
        stop = queued_items + n;
        while (queued_items < stop)
        begin
            if (frame_no < 6)
                kind = frame_kind_t'(frame_no);
            else
            begin
                r = $urandom_range(0, 99);
                kind = (r < 35) ? FR_INSERT :
                       (r < 50) ? FR_APPEND :
                       (r < 65) ? FR_ZERO_THIRD :
                       (r < 80) ? FR_OTHER_TYPE :
                       (r < 92) ? FR_CUT : FR_NOISE;
            end
            frame_no++;
            add_frame(kind);
        end
    endfunction

    task automatic program_regs(input logic [47:0] src, input logic [47:0] dst,
                                input logic bc, input logic [7:0] ch);
        logic [1:0]  regs [4];
        logic [47:0] vals [4];
        regs = '{bcsa_pkg::CFG_SOURCE_ADDRESS, bcsa_pkg::CFG_DEST_ADDRESS,
                 bcsa_pkg::CFG_BROADCAST_MODE, bcsa_pkg::CFG_NEW_CHANNEL};
        vals = '{src, dst, {47'd0, bc}, {40'd0, ch}};
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
        end
        @(negedge clk);
        cfg_write  <= 1'b0;
        m_src      = src;
        m_dst      = dst;
        m_bcast    = bc;
        m_new_chan = ch;
    endtask

    task automatic settle();
        while (taken_items != queued_items || rewritten_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        in_item_t it;
        if (!rst_n)
            push <= 1'b0;
        else if (!push || in_taken)
        begin
            if (tx_gap > 0)
            begin
                push   <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (byte_feed.size() > 0)
            begin
                it = byte_feed.pop_front();
                push    <= 1'b1;
                in_byte <= it.data;
                in_last <= it.last;
                if (tx_calm > 0)
                    tx_calm <= tx_calm - 1;
                else
                begin
                    tx_gap <= gap_len();
                    if ($urandom_range(0, 19) == 0)
                        tx_calm <= $urandom_range(20, 60);
                end
            end
            else
                push <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (choke_req && !choke_done)
        begin
            pop        <= 1'b0;
            rx_hold    <= CHOKE_CYCLES;
            choke_done <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            pop     <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
        begin
            pop <= 1'b1;
            if (rx_calm > 0)
                rx_calm <= rx_calm - 1;
            else
            begin
                rx_hold <= gap_len();
                if ($urandom_range(0, 19) == 0)
                    rx_calm <= $urandom_range(20, 60);
            end
        end
    end

    // input beats feed the predictor, output beats are checked in order
    always @(posedge clk)
    begin
        beat_t want;
        beat_t got;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= push && !full;
            if (push && !full)
            begin
                rewrite_byte(in_byte, in_last);
                taken_items <= taken_items + 1;
            end
            if (pop && !empty)
            begin
                got = {out_byte, out_last, is_beacon, old_channel, channel_found};
                if (rewritten_q.size() == 0)
                begin
                    if (bad_beats < 10)
                        $display("extra beat: byte %02h last %0b bcn %0b chan %02h found %0b",
                                 got.data, got.last, got.beacon, got.chan, got.found);
                    bad_beats++;
                end
                else
                begin
                    want = rewritten_q.pop_front();
                    if (got !== want)
                    begin
                        if (bad_beats < 10)
                            $display(
                                "mismatch: want %02h %0b %0b %02h %0b, got %02h %0b %0b %02h %0b",
                                want.data, want.last, want.beacon, want.chan, want.found,
                                got.data, got.last, got.beacon, got.chan, got.found);
                        bad_beats++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] fb[$];
        m_src      = '0;
        m_dst      = '1;
        m_bcast    = 1'b1;
        m_new_chan = 8'h01;
        clear_frame_state();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // tiny frames: single bytes, huge and short radiotap lengths, cut beacon
        fb = '{8'h00};
        add_bytes(fb);
        fb = '{8'hFF};
        add_bytes(fb);
        fb = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00};
        add_bytes(fb);
        fb = '{8'hFF, 8'h00, 8'h02, 8'h00, 8'h80, 8'h00, 8'h00};
        add_bytes(fb);
        fb = '{8'h00, 8'h00, 8'h04, 8'h00, 8'h83, 8'h00, 8'h00, 8'h00, 8'hAA, 8'h55, 8'hFF};
        add_bytes(fb);
        run_frames(ITEMS_PER_PHASE);
        settle();

        program_regs('1, '0, 1'b0, 8'h00);
        run_frames(ITEMS_PER_PHASE);
        // long receiver stall while the sender keeps offering
        choke_req <= 1'b1;
        settle();

        program_regs('0, {16'($urandom), 32'($urandom)}, 1'b1, 8'hFF);
        run_frames(ITEMS_PER_PHASE);
        settle();

        program_regs({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                     1'b0, rand_octet());
        run_frames(ITEMS_PER_PHASE);
        add_frame(FR_LONG);
        settle();

        if (bad_beats == 0 && rewritten_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
